// ===== src/khrt_pkg.sv =====
package khrt_pkg;

  // Counter and register widths
  localparam int CNT_W      = 16;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;
  localparam int KIND_W     = 3;

  // Counter wraps from this value back to 2
  localparam logic [CNT_W-1:0] COUNT_WRAP = 16'd64999;

  // Register reset values
  localparam logic [CNT_W-1:0] DOWN_DELAY_RST   = 16'd3;
  localparam logic [CNT_W-1:0] HOLD_DELAY_RST   = 16'd50;
  localparam logic [CNT_W-1:0] REPEAT_DELAY_RST = 16'd10;

  // Register indexes (word address)
  localparam logic [1:0] REG_DOWN_DELAY   = 2'd0;
  localparam logic [1:0] REG_HOLD_DELAY   = 2'd1;
  localparam logic [1:0] REG_REPEAT_DELAY = 2'd2;

  // Remainder unit: two quotient bits per cycle
  localparam int REM_BITS  = 2;
  localparam int REM_STEPS = CNT_W / REM_BITS;
  localparam int REM_SW    = $clog2(REM_STEPS);

  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_DOWN   = 2'd1,
    PH_HOLD   = 2'd2,
    PH_REPEAT = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    EV_DOWN      = 3'd0,
    EV_HOLD      = 3'd1,
    EV_REPEAT    = 3'd2,
    EV_UP_BEFORE = 3'd3,
    EV_UP_AFTER  = 3'd4
  } event_kind_t;

  // One entry of the per-key state memory
  typedef struct packed {
    phase_t            ph;
    logic [CNT_W-1:0]  cnt;
  } key_ent_t;

  // Remainder unit request and response
  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

// ===== src/khrt_rem.sv =====
module khrt_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  khrt_pkg::rem_req_t req,
  output khrt_pkg::rem_rsp_t rsp
);
  import khrt_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [REM_SW-1:0]   step_r;
  logic [CNT_W-1:0]    num_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    div_r;
  logic [CNT_W-1:0]    num_nxt;
  logic [CNT_W-1:0]    rem_nxt;

  // Run REM_BITS restoring steps
  always_comb begin
    logic [CNT_W:0] t;
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int i = 0; i < REM_BITS; i++) begin
      t = {rem_nxt, num_nxt[CNT_W-1]};
      num_nxt = {num_nxt[CNT_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      rem_nxt = t[CNT_W-1:0];
    end
  end

  // Control: load on start, step while busy, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == REM_SW'(REM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

// ===== src/keypad_hold_repeat_tracker_core.sv =====
// Keypad hold/repeat tracker: one tick of pressed keys in, zero to NUM_KEYS events out.
// Keys are visited one by one out of a registered-read state memory, each through the look
// and put states, plus a wait on the 2-bit-per-cycle remainder unit for a key past hold.
// A new tick is taken only in the idle state, after the last one has ended; output stalls hold the walk.
// Reset (synchronous, rst_n low): delays return to 3/50/10, every key reads as
// count zero and phase none, the output is empty; no clearing pass is needed.
module keypad_hold_repeat_tracker_core #(
  parameter int NUM_KEYS = 4,
  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // tick input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [NUM_KEYS-1:0]         in_pressed_mask,
  // event output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [KEY_W-1:0]            out_key_index,
  output logic [khrt_pkg::KIND_W-1:0] out_event_kind,
  output logic                        out_last_event,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [khrt_pkg::CFG_AW-1:0] paddr,
  input  logic [khrt_pkg::CFG_DW-1:0] pwdata,
  output logic [khrt_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import khrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_PUT,
    S_END
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     down_delay_r;
  logic [CNT_W-1:0]     hold_delay_r;
  logic [CNT_W-1:0]     repeat_delay_r;

  logic [NUM_KEYS-1:0]  mask_r;
  logic [KEY_W-1:0]     key_r;
  logic [CNT_W-1:0]     cnt_r;
  phase_t               ph_r;
  logic                 send_r;
  event_kind_t          kind_r;

  logic                 pend_v_r;
  logic [KEY_W-1:0]     pend_key_r;
  event_kind_t          pend_kind_r;

  logic                 out_valid_r;
  logic [KEY_W-1:0]     out_key_r;
  event_kind_t          out_kind_r;
  logic                 out_last_r;

  // State memory and its valid bits
  key_ent_t             mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  vld_r;
  key_ent_t             rd_q_r;
  logic                 rd_vld_r;
  logic                 rd_en;
  logic [KEY_W-1:0]     rd_addr;
  logic                 mem_we;
  key_ent_t             wr_ent;

  rem_req_t             rem_req;
  rem_rsp_t             rem_rsp;

  logic                 cfg_wr;
  logic                 accept;
  logic                 last_key;
  logic                 slot_free;
  logic                 put_go;
  logic                 end_go;
  logic                 push;
  logic                 push_last;

  logic [CNT_W-1:0]     cur_cnt;
  phase_t               cur_ph;
  logic                 pressed;
  logic [CNT_W-1:0]     base_cnt;
  logic [CNT_W-1:0]     inc_cnt;
  logic                 down_hit;
  logic                 hold_hit;
  phase_t               ph_a;
  phase_t               ph_b;
  logic                 need_rep;
  logic                 look_send;
  event_kind_t          look_kind;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_delay_r   <= DOWN_DELAY_RST;
      hold_delay_r   <= HOLD_DELAY_RST;
      repeat_delay_r <= REPEAT_DELAY_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DOWN_DELAY:   down_delay_r   <= pwdata[CNT_W-1:0];
        REG_HOLD_DELAY:   hold_delay_r   <= pwdata[CNT_W-1:0];
        REG_REPEAT_DELAY: repeat_delay_r <= pwdata[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DOWN_DELAY:   prdata = {{(CFG_DW-CNT_W){1'b0}}, down_delay_r};
      REG_HOLD_DELAY:   prdata = {{(CFG_DW-CNT_W){1'b0}}, hold_delay_r};
      REG_REPEAT_DELAY: prdata = {{(CFG_DW-CNT_W){1'b0}}, repeat_delay_r};
      default:          prdata = '0;
    endcase
  end

  // Handshake and sequencing conditions
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_key  = (key_r == KEY_W'(NUM_KEYS - 1));
  assign slot_free = !out_valid_r || out_ready;
  assign put_go    = !(send_r && pend_v_r && !slot_free);
  assign end_go    = !pend_v_r || slot_free;

  // Read the next key's entry on accept or when advancing
  assign rd_en   = accept || (state_r == S_PUT && put_go && !last_key);
  assign rd_addr = accept ? '0 : key_r + 1'b1;

  assign mem_we     = (state_r == S_PUT) && put_go;
  assign wr_ent.ph  = ph_r;
  assign wr_ent.cnt = cnt_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[key_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[key_r] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Step one key: advance the count, walk the phase and pick the event
  always_comb begin
    cur_cnt  = rd_vld_r ? rd_q_r.cnt : '0;
    cur_ph   = rd_vld_r ? rd_q_r.ph : PH_NONE;
    pressed  = mask_r[key_r];
    base_cnt = (cur_cnt >= COUNT_WRAP) ? CNT_W'(1) : cur_cnt;
    inc_cnt  = base_cnt + 1'b1;
    down_hit = (inc_cnt >= down_delay_r) && (inc_cnt < hold_delay_r) && (cur_ph == PH_NONE);
    ph_a     = down_hit ? PH_DOWN : cur_ph;
    hold_hit = (inc_cnt >= hold_delay_r) && (ph_a == PH_DOWN);
    ph_b     = hold_hit ? PH_HOLD : ph_a;
    need_rep = pressed && (repeat_delay_r != '0) && (ph_b == PH_HOLD || ph_b == PH_REPEAT);
    if (pressed) begin
      look_send = down_hit || hold_hit;
      case (ph_b)
        PH_DOWN: look_kind = EV_DOWN;
        PH_HOLD: look_kind = EV_HOLD;
        default: look_kind = EV_REPEAT;
      endcase
    end else begin
      look_send = (cur_ph != PH_NONE);
      look_kind = (cur_ph == PH_DOWN) ? EV_UP_BEFORE : EV_UP_AFTER;
    end
  end

  // Repeat test: count modulo repeat delay
  assign rem_req.start    = (state_r == S_LOOK) && need_rep;
  assign rem_req.dividend = inc_cnt;
  assign rem_req.divisor  = repeat_delay_r;

  khrt_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // Output push: a held event goes out once the next one or the tick end is known
  assign push      = ((state_r == S_PUT) && send_r && pend_v_r && slot_free)
                  || ((state_r == S_END) && pend_v_r && slot_free);
  assign push_last = (state_r == S_END);

  // Sequencer, held event and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      key_r       <= '0;
      send_r      <= 1'b0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
        out_key_r   <= pend_key_r;
        out_kind_r  <= pend_kind_r;
        out_last_r  <= push_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            mask_r  <= in_pressed_mask;
            key_r   <= '0;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          cnt_r   <= pressed ? inc_cnt : '0;
          ph_r    <= pressed ? ph_b : PH_NONE;
          send_r  <= look_send;
          kind_r  <= look_kind;
          state_r <= need_rep ? S_DIV : S_PUT;
        end
        S_DIV: begin
          if (rem_rsp.done) begin
            if (rem_rsp.zero) begin
              ph_r   <= PH_REPEAT;
              send_r <= 1'b1;
              kind_r <= EV_REPEAT;
            end
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_go) begin
            if (send_r) begin
              pend_v_r    <= 1'b1;
              pend_key_r  <= key_r;
              pend_kind_r <= kind_r;
            end
            if (last_key) begin
              state_r <= S_END;
            end else begin
              key_r   <= key_r + 1'b1;
              state_r <= S_LOOK;
            end
          end
        end
        S_END: begin
          if (end_go) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_index  = out_key_r;
  assign out_event_kind = out_kind_r;
  assign out_last_event = out_last_r;

`ifndef SYNTH
  // A new tick never starts with an event still held back
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r)
    else $error("held event left over at tick start");

  // The remainder unit only answers while the sequencer waits for it
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> (state_r == S_DIV))
    else $error("remainder result outside wait state");

  // A released key is written back with a zero count
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && wr_ent.ph == PH_NONE) |-> (wr_ent.cnt == '0) || mask_r[key_r])
    else $error("cleared key keeps a count");

  // The final event of a tick leaves only from the tick end
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && !$past(out_valid_r && !out_ready)) |->
      $past(state_r == S_END))
    else $error("last event pushed mid tick");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import khrt_pkg::*;

  localparam int NUM_KEYS       = 4;
  localparam int KEY_W          = 2;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    event_kind_t      kind;
    logic             last;
  } key_event_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [NUM_KEYS-1:0] in_pressed_mask = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KEY_W-1:0]    out_key_index;
  logic [KIND_W-1:0]   out_event_kind;
  logic                out_last_event;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Shadow copy of the delays and the per-key tracking state
  logic [CNT_W-1:0] dly_down = DOWN_DELAY_RST;
  logic [CNT_W-1:0] dly_hold = HOLD_DELAY_RST;
  logic [CNT_W-1:0] dly_repeat = REPEAT_DELAY_RST;
  logic [CNT_W-1:0] key_count [NUM_KEYS] = '{default: '0};
  phase_t           key_state [NUM_KEYS] = '{default: PH_NONE};

  key_event_t  pending_events [$];
  int unsigned mismatch_count = 0;
  bit          sender_gaps = 1'b1;
  int unsigned holdoff_req = 0;
  int unsigned holdoff_ack = 0;
  int unsigned idle_cycles = 0;

  keypad_hold_repeat_tracker_core #(.NUM_KEYS(NUM_KEYS)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pressed_mask (in_pressed_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_index   (out_key_index),
    .out_event_kind  (out_event_kind),
    .out_last_event  (out_last_event),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance every key by one tick and queue the events it reports
  task automatic track_tick(input logic [NUM_KEYS-1:0] mask);
    key_event_t       tick_events [$];
    key_event_t       ev;
    logic [CNT_W-1:0] c;
    phase_t           ph;
    logic             fire;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ph = key_state[k];
      fire = 1'b0;
      ev.key = KEY_W'(k);
      ev.last = 1'b0;
      if (mask[k]) begin
        c = key_count[k];
        if (c >= COUNT_WRAP) c = CNT_W'(1);
        c = c + 1'b1;
        key_count[k] = c;
        if (c >= dly_down && c < dly_hold && ph == PH_NONE) begin
          ph = PH_DOWN;
          fire = 1'b1;
        end
        if (c >= dly_hold && ph == PH_DOWN) begin
          ph = PH_HOLD;
          fire = 1'b1;
        end
        if (dly_repeat != 0 && (c % dly_repeat) == 0 &&
            (ph == PH_HOLD || ph == PH_REPEAT)) begin
          ph = PH_REPEAT;
          fire = 1'b1;
        end
        key_state[k] = ph;
        case (ph)
          PH_DOWN: ev.kind = EV_DOWN;
          PH_HOLD: ev.kind = EV_HOLD;
          default: ev.kind = EV_REPEAT;
        endcase
      end else begin
        if (ph == PH_DOWN) begin
          ev.kind = EV_UP_BEFORE;
          fire = 1'b1;
        end else if (ph == PH_HOLD || ph == PH_REPEAT) begin
          ev.kind = EV_UP_AFTER;
          fire = 1'b1;
        end
        key_count[k] = '0;
        key_state[k] = PH_NONE;
      end
      if (fire) tick_events.push_back(ev);
    end
    if (tick_events.size() != 0) tick_events[tick_events.size()-1].last = 1'b1;
    foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
  endtask

  // Offer one tick after an optional gap, hold it until accepted
  task automatic send_tick(input logic [NUM_KEYS-1:0] mask);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (sender_gaps) begin
      r = $urandom_range(0, 99);
      if (r < 40) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 95) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 50);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pressed_mask <= mask;
    do @(posedge clk); while (!in_ready);
    track_tick(mask);
  endtask

  // Drop valid, wait for every queued event, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back unless it is the unused one
  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    logic [CFG_DW-1:0] word;
    word = $urandom();
    word[CNT_W-1:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DOWN_DELAY:   dly_down = val;
      REG_HOLD_DELAY:   dly_hold = val;
      REG_REPEAT_DELAY: dly_repeat = val;
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[CNT_W-1:0] !== val) begin
        $error("delay register %0d: expected %0d, actual %0d", idx, val,
               prdata[CNT_W-1:0]);
        mismatch_count++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delays(input logic [CNT_W-1:0] d, input logic [CNT_W-1:0] h,
                            input logic [CNT_W-1:0] r);
    write_reg(REG_DOWN_DELAY, d);
    write_reg(REG_HOLD_DELAY, h);
    write_reg(REG_REPEAT_DELAY, r);
  endtask

  // Reset delays: down on the third tick, released before hold
  task automatic test_reset_values();
    send_tick(4'hF);
    send_tick(4'hF);
    send_tick(4'hF);
    send_tick(4'h8);
    send_tick(4'h0);
    wait_drained();
  endtask

  // Hold and repeat landing on one tick, plain hold, and releases after hold
  task automatic test_hold_repeat();
    set_delays(16'd2, 16'd3, 16'd3);
    repeat (6) send_tick(4'hF);
    send_tick(4'hA);
    send_tick(4'h0);
    wait_drained();
    set_delays(16'd1, 16'd2, 16'd5);
    repeat (5) send_tick(4'h1);
    send_tick(4'h0);
    wait_drained();
  endtask

  // Zero repeat delay never repeats, zero hold delay never reports,
  // a write past the last register changes nothing
  task automatic test_zero_delays();
    set_delays(16'd1, 16'd2, 16'd0);
    write_reg(REG_UNUSED, 16'd1);
    repeat (3) send_tick(4'h3);
    send_tick(4'h0);
    wait_drained();
    set_delays(16'd1, 16'd0, 16'd1);
    send_tick(4'hF);
    send_tick(4'hF);
    send_tick(4'h0);
    wait_drained();
  endtask

  // Stall the output for a long stretch while every key repeats on each tick after the first
  task automatic test_output_backpressure();
    set_delays(16'd1, 16'd2, 16'd1);
    sender_gaps = 1'b0;
    holdoff_req++;
    repeat (16) send_tick(4'hF);
    send_tick(4'h0);
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  // Random press runs with some noise, across several delay settings
  task automatic test_random_sequences();
    logic [NUM_KEYS-1:0] held;
    logic [NUM_KEYS-1:0] mask;
    logic [CNT_W-1:0]    d;
    held = '0;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_delays(16'd2, 16'd6, 16'd3);
        1: set_delays(16'd1, 16'd2, 16'd1);
        2: begin
          d = CNT_W'($urandom_range(1, 5));
          set_delays(d, d + CNT_W'($urandom_range(0, 8)), CNT_W'($urandom_range(1, 6)));
        end
        3: set_delays(16'd65000, 16'd65000, 16'd65000);
        4: set_delays(CNT_W'($urandom()), CNT_W'($urandom()), CNT_W'($urandom()));
        default: set_delays(16'd1, 16'd4, 16'd2);
      endcase
      repeat (55) begin
        if ($urandom_range(0, 9) < 8) begin
          for (int k = 0; k < NUM_KEYS; k++)
            if ($urandom_range(0, 5) == 0) held[k] = ~held[k];
          mask = held;
        end else begin
          mask = NUM_KEYS'($urandom_range(0, 15));
        end
        send_tick(mask);
      end
      wait_drained();
    end
  endtask

  // Drive out_ready: random runs and stalls, or a long hold-off on request
  int unsigned ready_run = 0;
  int unsigned stall_run = 0;
  int unsigned holdoff_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_req != holdoff_ack) begin
      holdoff_ack = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else if (ready_run != 0) begin
      ready_run--;
      out_ready <= 1'b1;
    end else if (stall_run != 0) begin
      stall_run--;
      out_ready <= 1'b0;
    end else begin
      ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 11);
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted event with the oldest expected one
  always @(posedge clk) begin
    key_event_t exp_ev;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected item: key_index %0d event_kind %0d last_event %0d",
               out_key_index, out_event_kind, out_last_event);
        mismatch_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_key_index !== exp_ev.key) begin
          $error("key_index: expected %0d, actual %0d", exp_ev.key, out_key_index);
          mismatch_count++;
        end
        if (out_event_kind !== exp_ev.kind) begin
          $error("event_kind: expected %0d, actual %0d", exp_ev.kind, out_event_kind);
          mismatch_count++;
        end
        if (out_last_event !== exp_ev.last) begin
          $error("last_event: expected %0d, actual %0d", exp_ev.last, out_last_event);
          mismatch_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("keypad_hold_repeat_tracker_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_hold_repeat();
    test_zero_delays();
    test_output_backpressure();
    test_random_sequences();
    if (mismatch_count == 0) begin
      $display("keypad_hold_repeat_tracker_core test passed");
    end else begin
      $display("keypad_hold_repeat_tracker_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/khrt_pkg.sv
src/khrt_rem.sv
src/keypad_hold_repeat_tracker_core.sv
bench/tb_top.sv
